@@ sv/nwst_pkg.sv @@
`timescale 1ns / 1ps
package nwst_pkg;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] Q_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

	// form select codes
	localparam logic [2:0] FORM_NONE    = 3'd0;
	localparam logic [2:0] FORM_METRIC  = 3'd1;
	localparam logic [2:0] FORM_SPATIAL = 3'd2;
	localparam logic [2:0] FORM_NULL_X  = 3'd3;
	localparam logic [2:0] FORM_BAD_T   = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_FORM_MODE       = 3'd0;
	localparam logic [2:0] CFG_CUBIC_GAIN      = 3'd1;
	localparam logic [2:0] CFG_DERIVATIVE_GAIN = 3'd2;
	localparam logic [2:0] CFG_BOX_GAIN        = 3'd3;

	// unit latencies
	localparam int MUL_LAT  = 5;
	localparam int DIV_STEP = 2;
	localparam int DIV_LAT  = 64 / DIV_STEP + 2;

	typedef struct packed {
		logic signed [63:0] val;
		logic               clip;
	} qres_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] lo;
		logic [63:0] q;
	} div_st_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? (~a) + 64'd1 : a;
	endfunction

	function automatic qres_t sat_pack(input logic neg, input logic [63:0] mag,
		input logic over);
		qres_t r;
		if (neg) begin
			if (over || mag > SIGN_BIT) begin
				r.val  = SIGN_BIT;
				r.clip = 1'b1;
			end else begin
				r.val  = (~mag) + 64'd1;
				r.clip = 1'b0;
			end
		end else begin
			if (over || mag > Q_MAX) begin
				r.val  = Q_MAX;
				r.clip = 1'b1;
			end else begin
				r.val  = mag;
				r.clip = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic qres_t q_add(input logic signed [63:0] a, input logic signed [63:0] b);
		qres_t r;
		r.val  = a + b;
		r.clip = 1'b0;
		if (a[63] == b[63] && r.val[63] != a[63]) begin
			r.val  = a[63] ? SIGN_BIT : Q_MAX;
			r.clip = 1'b1;
		end
		return r;
	endfunction

	function automatic qres_t q_sub(input logic signed [63:0] a, input logic signed [63:0] b);
		qres_t r;
		r.val  = a - b;
		r.clip = 1'b0;
		if (a[63] != b[63] && r.val[63] != a[63]) begin
			r.val  = a[63] ? SIGN_BIT : Q_MAX;
			r.clip = 1'b1;
		end
		return r;
	endfunction

	// restoring division, DIV_STEP quotient bits
	function automatic div_st_t div_steps(input logic [63:0] d, input div_st_t st);
		div_st_t s;
		logic [64:0] r;
		s = st;
		for (int i = 0; i < DIV_STEP; i++) begin
			r    = {s.rem, s.lo[63]};
			s.lo = {s.lo[62:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r   = r - {1'b0, d};
				s.q = {s.q[62:0], 1'b1};
			end else begin
				s.q = {s.q[62:0], 1'b0};
			end
			s.rem = r[63:0];
		end
		return s;
	endfunction

endpackage

@@ sv/nwst_delay.sv @@
`timescale 1ns / 1ps
module nwst_delay #(
	parameter int W = 64,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[N-1];

endmodule

@@ sv/nwst_mul.sv @@
`timescale 1ns / 1ps
module nwst_mul import nwst_pkg::*; #(
	parameter int FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p,
	output logic               clip
);

	localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

	logic [63:0]  xm_s1, ym_s1;
	logic         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [63:0]  p0_s2, p1_s2, p2_s2, p3_s2;
	logic [64:0]  mid_s3;
	logic [127:0] base_s3, full_s4;
	qres_t        res_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s1   <= mag64(a);
			ym_s1   <= mag64(b);
			neg_s1  <= a[63] ^ b[63];
			// four 32x32 partial products
			p0_s2   <= xm_s1[31:0] * ym_s1[31:0];
			p1_s2   <= xm_s1[31:0] * ym_s1[63:32];
			p2_s2   <= xm_s1[63:32] * ym_s1[31:0];
			p3_s2   <= xm_s1[63:32] * ym_s1[63:32];
			neg_s2  <= neg_s1;
			mid_s3  <= {1'b0, p1_s2} + {1'b0, p2_s2};
			base_s3 <= {p3_s2, p0_s2} + HALF;
			neg_s3  <= neg_s2;
			full_s4 <= base_s3 + ({63'd0, mid_s3} << 32);
			neg_s4  <= neg_s3;
			res_s5  <= sat_pack(neg_s4, full_s4[FRAC_BITS +: 64],
				|full_s4[127:FRAC_BITS+64]);
		end
	end

	assign p    = res_s5.val;
	assign clip = res_s5.clip;

endmodule

@@ sv/nwst_div.sv @@
`timescale 1ns / 1ps
module nwst_div import nwst_pkg::*; #(
	parameter int FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] q,
	output logic               clip
);

	localparam int NST = 64 / DIV_STEP;

	div_st_t     st_s  [NST+1];
	logic [63:0] d_s   [NST+1];
	logic        ovf_s [NST+1];
	logic        neg_s [NST+1];
	qres_t       res_s;

	logic [63:0] x_m, d_m, hi_m;

	assign x_m  = mag64(a);
	assign d_m  = mag64(b);
	assign hi_m = x_m >> (64 - FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			// quotient would not fit, or zero divisor
			st_s[0]  <= '{rem: hi_m, lo: x_m << FRAC_BITS, q: 64'd0};
			d_s[0]   <= d_m;
			ovf_s[0] <= hi_m >= d_m;
			neg_s[0] <= a[63] ^ b[63];
			for (int k = 0; k < NST; k++) begin
				st_s[k+1]  <= div_steps(d_s[k], st_s[k]);
				d_s[k+1]   <= d_s[k];
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
			end
			res_s <= sat_pack(neg_s[NST], st_s[NST].q, ovf_s[NST]);
		end
	end

	assign q    = res_s.val;
	assign clip = res_s.clip;

endmodule

@@ sv/nonlinear_wave_source_term.sv @@
`timescale 1ns / 1ps
// Nonlinear wave source term: per grid point, N = mu*phi^3 + lambda*Q, optionally divided
// by the clamped (1 - alpha2*phi), all in signed fixed point with FRAC_BITS fraction
// bits, saturating, with a sticky saturated flag per item. Fully pipelined: one item
// per cycle while the output is not stalled. The depth is set by two
// dependent radix-4 dividers (the lapse quotients, with the radius quotient running
// alongside, then the box divisor), each 34 stages, plus the 5-stage square multipliers
// ahead of the lapse divider, the 5-stage lambda*Q multiplier, an operand register, three
// form-sum stages, the numerator register and the output register. Any stall
// holds the whole pipe; an input register in front takes one more item while the
// output waits. Registers must only be written while no item is in flight.
module nonlinear_wave_source_term import nwst_pkg::*; #(
	parameter int FRAC_BITS = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] field_value,
	input  logic signed [63:0] time_rate,
	input  logic signed [63:0] grad_tortoise,
	input  logic signed [63:0] grad_angle,
	input  logic signed [63:0] grad_axial,
	input  logic [62:0]        radius,
	input  logic signed [63:0] lapse,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] source_value,
	output logic               saturated
);

	localparam logic [63:0] ONE_U = 64'd1 << FRAC_BITS;
	localparam logic signed [63:0] ONE_Q       = ONE_U;
	localparam logic signed [63:0] LAPSE_FLOOR = (ONE_U + 64'd5000000000) / 64'd10000000000;
	localparam logic signed [63:0] DENOM_MIN   = (ONE_U + 64'd50000000) / 64'd100000000;

	// schedule, in pipe cycles after the input register
	localparam int TA     = MUL_LAT;            // squares, alpha2*phi
	localparam int TB     = TA + 1;             // divider operands ready
	localparam int T_CUB  = 3 * MUL_LAT;        // mu*phi^3 done
	localparam int T_ANG  = DIV_LAT + MUL_LAT;  // (phith/r)^2 done
	localparam int T_Q    = TB + DIV_LAT;       // lapse quotients done
	localparam int T_FORM = T_Q + 3;            // form summed
	localparam int T_LF   = T_FORM + MUL_LAT;   // lambda*Q done
	localparam int T_NUM  = T_LF + 1;           // numerator
	localparam int T_OUT  = T_NUM + DIV_LAT;    // box quotient done

	logic adv;

	// config registers
	logic [2:0]         form_mode_q;
	logic signed [63:0] cubic_gain_q, derivative_gain_q, box_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			form_mode_q       <= FORM_NONE;
			cubic_gain_q      <= '0;
			derivative_gain_q <= '0;
			box_gain_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FORM_MODE:       form_mode_q       <= cfg_data[2:0];
				CFG_CUBIC_GAIN:      cubic_gain_q      <= cfg_data;
				CFG_DERIVATIVE_GAIN: derivative_gain_q <= cfg_data;
				CFG_BOX_GAIN:        box_gain_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register; fills while the pipe is held if it is empty
	logic               v_s0;
	logic signed [63:0] phi_s0, p_s0, px_s0, pth_s0, pz_s0, ff_s0;
	logic [62:0]        r_s0;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv || !v_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s0 <= 1'b0;
		else if (in_ready) v_s0 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			phi_s0 <= field_value;
			p_s0   <= time_rate;
			px_s0  <= grad_tortoise;
			pth_s0 <= grad_angle;
			pz_s0  <= grad_axial;
			r_s0   <= radius;
			ff_s0  <= (lapse > LAPSE_FLOOR) ? lapse : LAPSE_FLOOR;
		end
	end

	// squares and alpha2*phi
	logic signed [63:0] phi2, px2, p2, pz2, bphi;
	logic               phi2_c, px2_c, p2_c, pz2_c, bphi_c;

	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_phi2 (.clk, .en(adv), .a(phi_s0), .b(phi_s0),
		.p(phi2), .clip(phi2_c));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_px2 (.clk, .en(adv), .a(px_s0), .b(px_s0),
		.p(px2), .clip(px2_c));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_p2 (.clk, .en(adv), .a(p_s0), .b(p_s0),
		.p(p2), .clip(p2_c));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_pz2 (.clk, .en(adv), .a(pz_s0), .b(pz_s0),
		.p(pz2), .clip(pz2_c));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_bphi (.clk, .en(adv), .a(box_gain_q), .b(phi_s0),
		.p(bphi), .clip(bphi_c));

	// cubic term: (mu * phi^2) * phi
	logic signed [63:0] t1, num0, phi_dc, num0_d;
	logic               phi2_c_d, t1_c, cub_pre_d, num0_c, cub_c_d;

	nwst_delay #(.W(64), .N(2 * TA)) u_phi_dly (.clk, .en(adv), .d(phi_s0), .q(phi_dc));
	nwst_delay #(.W(1), .N(TA)) u_phi2c_dly (.clk, .en(adv), .d(phi2_c), .q(phi2_c_d));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_t1 (.clk, .en(adv), .a(cubic_gain_q), .b(phi2),
		.p(t1), .clip(t1_c));
	nwst_delay #(.W(1), .N(TA)) u_cubc_dly (.clk, .en(adv), .d(phi2_c_d | t1_c),
		.q(cub_pre_d));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_num0 (.clk, .en(adv), .a(t1), .b(phi_dc),
		.p(num0), .clip(num0_c));
	nwst_delay #(.W(65), .N(T_LF - T_CUB)) u_num0_dly (.clk, .en(adv),
		.d({num0, cub_pre_d | num0_c}), .q({num0_d, cub_c_d}));

	// angular quotient phith/r, then squared
	logic signed [63:0] ang0, ang2, ang_d;
	logic               ang0_c, ang0_c_d, ang2_c, ang_c_d;

	nwst_div #(.FRAC_BITS(FRAC_BITS)) u_dang (.clk, .en(adv), .a(pth_s0),
		.b(signed'({1'b0, r_s0})), .q(ang0), .clip(ang0_c));
	nwst_delay #(.W(1), .N(MUL_LAT)) u_angc_dly (.clk, .en(adv), .d(ang0_c), .q(ang0_c_d));
	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_ang2 (.clk, .en(adv), .a(ang0), .b(ang0),
		.p(ang2), .clip(ang2_c));
	nwst_delay #(.W(65), .N(T_Q - T_ANG)) u_ang_dly (.clk, .en(adv),
		.d({ang2, ang0_c_d | ang2_c}), .q({ang_d, ang_c_d}));

	// divider operands and box divisor
	logic signed [63:0] dnum_s6, p2_s6, den_s6, ff_d;
	logic               pre_c_s6, den_c_s6;
	qres_t              dif, dsub;
	logic signed [63:0] den_m;

	always_comb begin
		dif   = q_sub(px2, p2);
		dsub  = q_sub(ONE_Q, bphi);
		den_m = dsub.val;
		if (!den_m[63] && den_m < DENOM_MIN) den_m = DENOM_MIN;
		else if (den_m[63] && den_m > -DENOM_MIN) den_m = -DENOM_MIN;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s6    <= p2;
			den_s6   <= den_m;
			den_c_s6 <= bphi_c | dsub.clip;
			case (form_mode_q) inside
				FORM_METRIC: begin
					dnum_s6  <= px2;
					pre_c_s6 <= px2_c | p2_c | pz2_c;
				end
				FORM_SPATIAL: begin
					dnum_s6  <= px2;
					pre_c_s6 <= px2_c | pz2_c;
				end
				FORM_NULL_X: begin
					dnum_s6  <= dif.val;
					pre_c_s6 <= px2_c | p2_c | dif.clip;
				end
				FORM_BAD_T: begin
					dnum_s6  <= p2;
					pre_c_s6 <= p2_c;
				end
				default: begin
					dnum_s6  <= px2;
					pre_c_s6 <= 1'b0;
				end
			endcase
		end
	end

	nwst_delay #(.W(64), .N(TB)) u_ff_dly (.clk, .en(adv), .d(ff_s0), .q(ff_d));

	// lapse quotients
	logic signed [63:0] q2, q3, pz2_d;
	logic               q2_c, q3_c, pre_c_d, pz2_dc;

	nwst_div #(.FRAC_BITS(FRAC_BITS)) u_d2 (.clk, .en(adv), .a(dnum_s6), .b(ff_d),
		.q(q2), .clip(q2_c));
	nwst_div #(.FRAC_BITS(FRAC_BITS)) u_d3 (.clk, .en(adv), .a(p2_s6), .b(ff_d),
		.q(q3), .clip(q3_c));
	nwst_delay #(.W(1), .N(T_Q - TB)) u_prec_dly (.clk, .en(adv), .d(pre_c_s6), .q(pre_c_d));
	nwst_delay #(.W(65), .N(T_Q - TA)) u_pz2_dly (.clk, .en(adv), .d({pz2, pz2_c}),
		.q({pz2_d, pz2_dc}));

	// form summation, three stages
	logic               metric, spatial_like;
	qres_t              sub_a, add_b, add_c;
	logic signed [63:0] fa_s, ang_s, pz2_s, pz2_s2, q2_s, q2_s2, fb_s, form_s;
	logic               fa_c_s, fb_c_s, form_c_s;

	assign metric       = form_mode_q == FORM_METRIC;
	assign spatial_like = metric || form_mode_q == FORM_SPATIAL;

	always_comb begin
		sub_a = q_sub(q2, q3);
		add_b = q_add(fa_s, ang_s);
		add_c = q_add(fb_s, pz2_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fa_s   <= metric ? sub_a.val : q2;
			fa_c_s <= pre_c_d | q2_c | (metric & (q3_c | sub_a.clip)) |
				(spatial_like & ang_c_d);
			ang_s  <= ang_d;
			pz2_s  <= pz2_d;
			q2_s   <= q2;

			fb_s   <= add_b.val;
			fb_c_s <= fa_c_s | (spatial_like & add_b.clip);
			pz2_s2 <= pz2_s;
			q2_s2  <= q2_s;

			case (form_mode_q) inside
				FORM_METRIC, FORM_SPATIAL: begin
					form_s   <= add_c.val;
					form_c_s <= fb_c_s | add_c.clip;
				end
				FORM_NULL_X, FORM_BAD_T: begin
					form_s   <= q2_s2;
					form_c_s <= fb_c_s;
				end
				default: begin
					form_s   <= '0;
					form_c_s <= 1'b0;
				end
			endcase
		end
	end

	// lambda * Q, added to the cubic term
	logic signed [63:0] lf, num_s, den_d;
	logic               lf_c, form_c_d, num_c_s;
	qres_t              nsum;

	nwst_mul #(.FRAC_BITS(FRAC_BITS)) u_lf (.clk, .en(adv), .a(derivative_gain_q), .b(form_s),
		.p(lf), .clip(lf_c));
	nwst_delay #(.W(1), .N(MUL_LAT)) u_formc_dly (.clk, .en(adv), .d(form_c_s), .q(form_c_d));

	assign nsum = q_add(num0_d, lf);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (derivative_gain_q != '0) begin
				num_s   <= nsum.val;
				num_c_s <= cub_c_d | form_c_d | lf_c | nsum.clip;
			end else begin
				num_s   <= num0_d;
				num_c_s <= cub_c_d;
			end
		end
	end

	// box division
	logic signed [63:0] q4, num_d;
	logic               q4_c, num_c_d, den_c_d;

	nwst_delay #(.W(64), .N(T_NUM - TB)) u_den_dly (.clk, .en(adv), .d(den_s6), .q(den_d));
	nwst_delay #(.W(1), .N(T_OUT - TB)) u_denc_dly (.clk, .en(adv), .d(den_c_s6),
		.q(den_c_d));
	nwst_div #(.FRAC_BITS(FRAC_BITS)) u_d4 (.clk, .en(adv), .a(num_s), .b(den_d),
		.q(q4), .clip(q4_c));
	nwst_delay #(.W(65), .N(DIV_LAT)) u_num_dly (.clk, .en(adv), .d({num_s, num_c_s}),
		.q({num_d, num_c_d}));

	// valid bits follow the data, cleared by reset
	logic               v_out;
	logic [T_OUT-1:0]   v_pipe_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_pipe_s <= '0;
		else if (adv) v_pipe_s <= {v_pipe_s[T_OUT-2:0], v_s0};
	end

	assign v_out = v_pipe_s[T_OUT-1];

	logic               out_valid_q;
	logic signed [63:0] result_q;
	logic               sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= v_out;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (box_gain_q != '0) begin
				result_q <= q4;
				sat_q    <= num_c_d | den_c_d | q4_c;
			end else begin
				result_q <= num_d;
				sat_q    <= num_c_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign source_value = result_q;
	assign saturated    = sat_q;

endmodule

@@ sv/nwst_checker.sv @@
`timescale 1ns / 1ps
module nwst_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] source_value,
	input logic               saturated
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(source_value) && $stable(saturated))
		else $error("result changed while held");

	// an empty output never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// input only blocks behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output stall");

endmodule

bind nonlinear_wave_source_term nwst_checker u_nwst_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.source_value(source_value),
	.saturated(saturated)
);

@@ tb/nonlinear_wave_source_term_test.sv @@
`timescale 1ns / 1ps
module nonlinear_wave_source_term_test;
	import nwst_pkg::*;

	localparam int FB = 40;
	localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FB;
	localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] Q_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
	// 1e-10 and 1e-8 rounded to the nearest code
	localparam logic signed [63:0] LAPSE_MIN = ((64'sd1 <<< FB) + 64'sd5000000000) / 64'sd10000000000;
	localparam logic signed [63:0] DIV_MIN = ((64'sd1 <<< FB) + 64'sd50000000) / 64'sd100000000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic signed [63:0] phi;
		logic signed [63:0] rate;
		logic signed [63:0] gx;
		logic signed [63:0] gth;
		logic signed [63:0] gz;
		logic [62:0]        r;
		logic signed [63:0] f;
	} point_t;

	typedef struct {
		logic signed [63:0] val;
		logic               sat;
	} source_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [63:0] field_value = '0, time_rate = '0, grad_tortoise = '0;
	logic signed [63:0] grad_angle = '0, grad_axial = '0, lapse = '0;
	logic [62:0] radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] source_value;
	logic saturated;

	nonlinear_wave_source_term uut (.*);

	always #1 clk = ~clk;

	// Predictor copy of the register file
	logic [2:0]         mode_cfg = FORM_NONE;
	logic signed [63:0] mu_cfg = '0, lambda_cfg = '0, alpha_cfg = '0;
	logic               clip_flag;

	source_t expected_sources[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;

	function automatic logic signed [63:0] fx_pack(input logic neg, input logic [63:0] mag,
		input logic over);
		if (neg) begin
			if (over || mag > 64'h8000_0000_0000_0000) begin
				clip_flag = 1'b1;
				return Q_MIN;
			end
			return -$signed(mag);
		end
		if (over || mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
			clip_flag = 1'b1;
			return Q_TOP;
		end
		return $signed(mag);
	endfunction

	function automatic logic [63:0] fx_abs(input logic signed [63:0] a);
		return a[63] ? -a : a;
	endfunction

	function automatic logic signed [63:0] fx_add(input logic signed [63:0] a, b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			clip_flag = 1'b1;
			return a[63] ? Q_MIN : Q_TOP;
		end
		return s;
	endfunction

	function automatic logic signed [63:0] fx_sub(input logic signed [63:0] a, b);
		logic signed [63:0] s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) begin
			clip_flag = 1'b1;
			return a[63] ? Q_MIN : Q_TOP;
		end
		return s;
	endfunction

	// exact product, rounded half away from zero
	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a, b);
		logic [127:0] p;
		p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
		p = (p + (128'd1 << (FB - 1))) >> FB;
		return fx_pack(a[63] ^ b[63], p[63:0], |p[127:64]);
	endfunction

	// (a << FB) / b, truncated toward zero
	function automatic logic signed [63:0] fx_div(input logic signed [63:0] a, b);
		logic [63:0] x, d;
		logic [127:0] q;
		x = fx_abs(a);
		d = fx_abs(b);
		if (d == 0) return fx_pack(a[63], 64'd0, 1'b1);
		if ((x >> (64 - FB)) >= d) return fx_pack(a[63] ^ b[63], 64'd0, 1'b1);
		q = ({64'd0, x} << FB) / {64'd0, d};
		return fx_pack(a[63] ^ b[63], q[63:0], 1'b0);
	endfunction

	function automatic logic signed [63:0] derivative_form(input point_t p);
		logic signed [63:0] ff, t, ang;
		ff = (p.f > LAPSE_MIN) ? p.f : LAPSE_MIN;
		case (mode_cfg)
			FORM_METRIC, FORM_SPATIAL: begin
				ang = fx_div(p.gth, $signed({1'b0, p.r}));
				ang = fx_mul(ang, ang);
				t = fx_div(fx_mul(p.gx, p.gx), ff);
				if (mode_cfg == FORM_METRIC) t = fx_sub(t, fx_div(fx_mul(p.rate, p.rate), ff));
				t = fx_add(t, ang);
				return fx_add(t, fx_mul(p.gz, p.gz));
			end
			FORM_NULL_X: return fx_div(fx_sub(fx_mul(p.gx, p.gx), fx_mul(p.rate, p.rate)), ff);
			FORM_BAD_T: return fx_div(fx_mul(p.rate, p.rate), ff);
			default: return '0;
		endcase
	endfunction

	function automatic source_t predict_source(input point_t p);
		source_t s;
		logic signed [63:0] num, den;
		clip_flag = 1'b0;
		num = fx_mul(fx_mul(mu_cfg, fx_mul(p.phi, p.phi)), p.phi);
		if (lambda_cfg != 0) num = fx_add(num, fx_mul(lambda_cfg, derivative_form(p)));
		if (alpha_cfg != 0) begin
			den = fx_sub(Q_ONE, fx_mul(alpha_cfg, p.phi));
			// keep the divisor away from zero, sign preserved
			if (den >= 0 && den < DIV_MIN) den = DIV_MIN;
			else if (den < 0 && den > -DIV_MIN) den = -DIV_MIN;
			num = fx_div(num, den);
		end
		s.val = num;
		s.sat = clip_flag;
		return s;
	endfunction

	// Random Q value: mix of full-range, moderate and tiny magnitudes
	function automatic logic signed [63:0] rand_q();
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1: return v;
			2: return $urandom_range(1) ? Q_MIN : Q_TOP;
			3: return v >>> $urandom_range(62, 40);
			default: return v >>> $urandom_range(36, 20);
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.phi = rand_q();
		p.rate = rand_q();
		p.gx = rand_q();
		p.gth = rand_q();
		p.gz = rand_q();
		p.f = rand_q();
		case ($urandom_range(9))
			0: p.r = '0;
			1: p.r = 63'({$urandom, $urandom});
			default: p.r = 63'($unsigned(rand_q()) >> ($urandom_range(20) + 1));
		endcase
		// some points near the lapse floor
		if ($urandom_range(9) == 0) p.f = $signed(64'($urandom_range(200)));
		return p;
	endfunction

	// Registers change only with no item in flight
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		in_valid <= 1'b0;
		while (expected_sources.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_FORM_MODE:       mode_cfg = data[2:0];
			CFG_CUBIC_GAIN:      mu_cfg = data;
			CFG_DERIVATIVE_GAIN: lambda_cfg = data;
			CFG_BOX_GAIN:        alpha_cfg = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [2:0] m, input logic signed [63:0] mu, lam, alp);
		write_reg(CFG_FORM_MODE, {61'd0, m});
		write_reg(CFG_CUBIC_GAIN, mu);
		write_reg(CFG_DERIVATIVE_GAIN, lam);
		write_reg(CFG_BOX_GAIN, alp);
	endtask

	// Called at a rising edge; returns at the edge where the item is taken,
	// leaving valid high for the caller to drop or reuse
	task automatic send_point(input point_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		field_value <= p.phi;
		time_rate <= p.rate;
		grad_tortoise <= p.gx;
		grad_angle <= p.gth;
		grad_axial <= p.gz;
		radius <= p.r;
		lapse <= p.f;
		expected_sources.push_back(predict_source(p));
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
	endtask

	function automatic point_t make_point(input logic signed [63:0] phi, rate, gx, gth, gz,
		input logic [62:0] r, input logic signed [63:0] f);
		point_t p;
		p.phi = phi; p.rate = rate; p.gx = gx; p.gth = gth; p.gz = gz; p.r = r; p.f = f;
		return p;
	endfunction

	// All registers at reset: result is zero
	task automatic test_reset_state();
		send_point(make_point(Q_TOP, Q_MIN, Q_TOP, Q_MIN, Q_TOP, '1, Q_MIN));
		send_point(make_point(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE[62:0], Q_ONE));
	endtask

	// Each form, field extremes, zero radius, lapse floor, divisor clamp, unused codes
	task automatic test_forms();
		logic signed [63:0] half;
		half = Q_ONE >>> 1;
		for (int m = 0; m < 8; m++) begin
			set_config(3'(m), half, Q_ONE, '0);
			send_point(make_point(Q_ONE, Q_ONE <<< 1, Q_ONE, Q_ONE, Q_ONE,
				Q_ONE[62:0] <<< 1, Q_ONE));
			if (m == FORM_METRIC || m == FORM_SPATIAL)
				send_point(make_point(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0, Q_ONE));
			// negative lapse lifted to the floor
			send_point(make_point(-Q_ONE, half, -half, half, -half, Q_ONE[62:0], -Q_ONE));
		end
		set_config(FORM_METRIC, Q_TOP, Q_MIN, '0);
		send_point(make_point(Q_MIN, Q_MIN, Q_TOP, Q_MIN, Q_TOP, '1, Q_TOP));
		send_point(make_point(Q_TOP, Q_TOP, Q_MIN, Q_TOP, Q_MIN, 63'd1, 64'sd0));
		// divisor exactly zero, just below zero, then just above: clamped with sign kept
		set_config(FORM_NULL_X, Q_ONE, half, Q_ONE);
		send_point(make_point(Q_ONE, half, Q_ONE, '0, '0, Q_ONE[62:0], Q_ONE));
		send_point(make_point(Q_ONE + 64'sd7, half, Q_ONE, '0, '0, Q_ONE[62:0], Q_ONE));
		send_point(make_point(Q_ONE - 64'sd7, half, -Q_ONE, '0, '0, Q_ONE[62:0], LAPSE_MIN));
		send_point(make_point(-Q_ONE, Q_MIN, Q_TOP, '0, '0, '0, Q_MIN));
		// index past the last register changes nothing
		write_reg(3'd5, {$urandom, $urandom});
		write_reg(3'd7, '1);
		send_point(make_point(half, half, half, half, half, Q_ONE[62:0], half));
	endtask

	task automatic test_random(input int send_pct, input int recv_pct, input int items);
		logic signed [63:0] lam, alp;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int blk = 0; blk < 6; blk++) begin
			lam = ($urandom_range(4) == 0) ? '0 : rand_q();
			alp = ($urandom_range(3) == 0) ? '0 : rand_q();
			set_config(3'($urandom_range(7)), rand_q(), lam, alp);
			for (int i = 0; i < items / 6; i++) send_point(rand_point());
		end
	endtask

	// Receiver: random stalls
	always @(posedge clk) begin
		if (arst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Result checker: outputs are stable at the falling edge
	always @(negedge clk) begin
		source_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sources.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item: %h sat %b", source_value, saturated);
			end else begin
				want = expected_sources.pop_front();
				if (source_value !== want.val || saturated !== want.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h sat %b, got %h sat %b",
							want.val, want.sat, source_value, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_forms();
		test_random(16, 84, 560);
		test_random(84, 16, 560);
		test_random(0, 0, 560);
		in_valid <= 1'b0;
		while (expected_sources.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
